/* rtl/ipd_payload_deframer_unit_assert.svh */
// ----------------------------------------------------------------------------
// ipd_payload_deframer_unit_assert.svh
// assertion macros shared by the deframer modules
// ----------------------------------------------------------------------------
`ifndef IPD_PAYLOAD_DEFRAMER_UNIT_ASSERT_SVH
`define IPD_PAYLOAD_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPD_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define IPD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ipd_pkg.sv */
// ----------------------------------------------------------------------------
// ipd_pkg
// characters, limits and shared types of the +IPD receive deframer
// ----------------------------------------------------------------------------
package ipd_pkg;

   localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
   localparam logic [7:0] CharI     = 8'h49;  // 'I'
   localparam logic [7:0] CharP     = 8'h50;  // 'P'
   localparam logic [7:0] CharD     = 8'h44;  // 'D'
   localparam logic [7:0] CharComma = 8'h2C;  // ','
   localparam logic [7:0] CharColon = 8'h3A;  // ':'
   localparam logic [7:0] CharZero  = 8'h30;  // '0'
   localparam logic [7:0] CharNine  = 8'h39;  // '9'

   // last length-character count that is still examined
   localparam logic [2:0] MaxLenCount = 3'd5;

   localparam int LenWidth = 16;

   // matcher report to the frame tracker
   typedef struct packed {
      logic start_length;
      logic link_id_valid;
   } match_status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CharZero:CharNine]};
   endfunction

endpackage

/* rtl/ipd_matchers.sv */
// ----------------------------------------------------------------------------
// ipd_matchers
// short "+IPD," and long "+IPD,<digit>," header matchers running side by side
// ----------------------------------------------------------------------------
module ipd_matchers
   import ipd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   output match_status_type status
);

   typedef enum logic [2:0] {
      PosIdle   = 3'd0,
      PosPlus   = 3'd1,
      PosI      = 3'd2,
      PosP      = 3'd3,
      PosD      = 3'd4,
      PosComma  = 3'd5,
      PosDigit  = 3'd6
   } match_pos_type;

   match_pos_type short_ff, short_in;
   match_pos_type long_ff, long_in;

   // common prefix advance, '+' at the first position holds there
   function automatic match_pos_type prefix_next(input match_pos_type pos,
                                                 input logic [7:0] c);
      match_pos_type nxt;
      nxt = PosIdle;
      case (pos)
         PosIdle:  if (c == CharPlus) nxt = PosPlus;
         PosPlus: begin
            if (c == CharI) nxt = PosI;
            else if (c == CharPlus) nxt = PosPlus;
         end
         PosI:     if (c == CharP) nxt = PosP;
         PosP:     if (c == CharD) nxt = PosD;
         PosD:     if (c == CharComma) nxt = PosComma;
         default:  nxt = PosIdle;
      endcase
      return nxt;
   endfunction

   // next matcher positions and match report
   always_comb begin
      logic short_hit;
      logic long_hit;
      logic link_hit;
      short_hit = 1'b0;
      long_hit  = 1'b0;
      link_hit  = 1'b0;

      if (short_ff == PosD && rx_byte == CharComma) begin
         short_in  = PosIdle;
         short_hit = 1'b1;
      end else begin
         short_in = prefix_next(short_ff, rx_byte);
         if (short_in == PosComma) short_in = PosIdle;
      end

      if (long_ff == PosComma && is_digit(rx_byte)) begin
         long_in  = PosDigit;
         link_hit = 1'b1;
      end else if (long_ff == PosDigit && rx_byte == CharComma) begin
         long_in  = PosIdle;
         long_hit = 1'b1;
      end else begin
         long_in = prefix_next(long_ff, rx_byte);
      end

      status.start_length  = short_hit | long_hit;
      status.link_id_valid = link_hit;
   end

   // matcher state
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= PosIdle;
         long_ff  <= PosIdle;
      end else if (step) begin
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

endmodule

/* rtl/ipd_frame.sv */
// ----------------------------------------------------------------------------
// ipd_frame
// length digit reader and payload counter of one +IPD frame
// ----------------------------------------------------------------------------
`include "ipd_payload_deframer_unit_assert.svh"

module ipd_frame
   import ipd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  match_status_type status,
   output logic             payload_valid
);

   logic [LenWidth-1:0] length_left_ff, length_left_in;
   logic                length_phase_ff, length_phase_in;
   logic                payload_phase_ff, payload_phase_in;
   logic [2:0]          len_count_ff, len_count_in;

   // payload phase, then length phase, then a header match restarts the length
   always_comb begin
      logic [LenWidth-1:0] times_ten;
      length_left_in   = length_left_ff;
      length_phase_in  = length_phase_ff;
      payload_phase_in = payload_phase_ff;
      len_count_in     = len_count_ff;
      payload_valid    = 1'b0;

      if (payload_phase_in) begin
         if (length_left_in != '0) begin
            length_left_in = length_left_in - 1'b1;
            payload_valid  = 1'b1;
         end else begin
            payload_phase_in = 1'b0;
            length_phase_in  = 1'b0;
            length_left_in   = '0;
         end
      end

      times_ten = (length_left_in << 3) + (length_left_in << 1);

      if (length_phase_in) begin
         if (len_count_in <= MaxLenCount) begin
            len_count_in = len_count_in + 1'b1;
            if (rx_byte == CharColon) begin
               length_phase_in  = 1'b0;
               len_count_in     = '0;
               payload_phase_in = 1'b1;
            end else if (is_digit(rx_byte)) begin
               length_left_in = times_ten + LenWidth'(rx_byte[3:0]);
            end
         end else begin
            len_count_in = '0;
         end
      end

      if (status.start_length) begin
         length_phase_in = 1'b1;
         len_count_in    = '0;
         length_left_in  = '0;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         length_left_ff   <= '0;
         length_phase_ff  <= 1'b0;
         payload_phase_ff <= 1'b0;
         len_count_ff     <= '0;
      end else if (step) begin
         length_left_ff   <= length_left_in;
         length_phase_ff  <= length_phase_in;
         payload_phase_ff <= payload_phase_in;
         len_count_ff     <= len_count_in;
      end
   end

   // checks
   `IPD_ASSERT_NOW(a_count_bound, 1'b1, len_count_ff <= 3'd6, "length count out of range")
   `IPD_ASSERT_NOW(a_both_phases, length_phase_ff && payload_phase_ff, length_left_ff == '0, "header restart during payload left a nonzero length")
   `IPD_ASSERT_NEXT(a_frame_close, step && payload_phase_ff && length_left_ff == '0, !payload_phase_ff, "frame not closed after last payload byte")

endmodule

/* rtl/ipd_payload_deframer_unit.sv */
// ----------------------------------------------------------------------------
// ipd_payload_deframer_unit
// receive deframer for +IPD modem data frames: one byte in, one result out
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one received modem byte per transfer (req_rx_byte).
//   rsp channel returns one result per byte: payload_valid/payload_byte
//   mark bytes inside a frame body, link_id_valid/link_id_char report the
//   connection digit of a "+IPD,<digit>," header.
//   A transfer is taken at a clock edge with valid high and stall low.
//   The result of an accepted byte passes the input register, then the
//   result register; one byte per cycle is sustained while rsp_stall is low,
//   set by the single input register and single result register.
//   When rsp_stall is held, the result register holds its item and the
//   input register can still take one more byte; req_stall rises only
//   when both registers are full and the result is not taken.
//   Reset (synchronous, active high) empties both registers and clears the
//   matchers and the frame state; no frame is open after reset.
// ----------------------------------------------------------------------------
`include "ipd_payload_deframer_unit_assert.svh"

module ipd_payload_deframer_unit
   import ipd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_payload_valid,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_link_id_valid,
   output logic [5:0] rsp_link_id_char
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_pv_ff, out_pv_in;
   logic [7:0] out_pb_ff, out_pb_in;
   logic       out_lv_ff, out_lv_in;
   logic [5:0] out_lc_ff, out_lc_in;

   logic             out_free;
   logic             step;
   logic             req_take;
   logic             payload_valid;
   match_status_type status;

   // handshake: the held byte moves on when the result register frees up
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   ipd_matchers u_matchers (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .status  (status)
   );

   ipd_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rx_byte       (in_byte_ff),
      .status        (status),
      .payload_valid (payload_valid)
   );

   // register next values
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_rx_byte : in_byte_ff;
      out_valid_in = step ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
      out_pv_in    = step ? payload_valid : out_pv_ff;
      out_pb_in    = step ? (payload_valid ? in_byte_ff : 8'h00) : out_pb_ff;
      out_lv_in    = step ? status.link_id_valid : out_lv_ff;
      out_lc_in    = step ? (status.link_id_valid ? in_byte_ff[5:0] : 6'h00)
                          : out_lc_ff;
   end

   // input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_pv_ff  <= out_pv_in;
      out_pb_ff  <= out_pb_in;
      out_lv_ff  <= out_lv_in;
      out_lc_ff  <= out_lc_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_pv_ff;
   assign rsp_payload_byte  = out_pb_ff;
   assign rsp_link_id_valid = out_lv_ff;
   assign rsp_link_id_char  = out_lc_ff;

   // checks
   `IPD_ASSERT_NOW(a_link_digit, rsp_valid && rsp_link_id_valid, rsp_link_id_char >= 6'd48 && rsp_link_id_char <= 6'd57, "link id is not a digit")
   `IPD_ASSERT_NOW(a_payload_zero, rsp_valid && !rsp_payload_valid, rsp_payload_byte == 8'h00, "payload byte not cleared outside a frame body")
   `IPD_ASSERT_NEXT(a_step_fills, step, out_valid_ff, "processed byte did not reach the result register")

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the +IPD receive deframer: bytes are streamed in
// under varying idle and stall patterns, each result is predicted in the
// bench and compared field by field in arrival order
// ----------------------------------------------------------------------------
module tb_top
   import ipd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StallLimit = 4000;
   localparam int unsigned HoldCycles = 250;
   localparam int unsigned TailCycles = 10;
   localparam int unsigned PrintLimit = 30;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       link_id_valid;
      logic [5:0] link_id_char;
   } deframe_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_payload_valid;
   logic [7:0] rsp_payload_byte;
   logic       rsp_link_id_valid;
   logic [5:0] rsp_link_id_char;

   // bench copy of the frame state
   logic [2:0]  short_pos;
   logic [2:0]  long_pos;
   logic [15:0] len_left;
   logic        length_on;
   logic        payload_on;
   logic [2:0]  len_count;

   deframe_result_type expected_q[$];
   int unsigned     errors = 0;
   int unsigned     bytes_sent = 0;
   int unsigned     idle_pct = 0;
   int unsigned     stall_pct = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     hold_seq = 0;
   int unsigned     hold_seen = 0;
   int unsigned     hold_cnt = 0;

   ipd_payload_deframer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_link_id_valid (rsp_link_id_valid),
      .rsp_link_id_char  (rsp_link_id_char)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic is_len_digit(input logic [7:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   // next position in "+IPD," for one byte
   function automatic logic [2:0] prefix_next(input logic [2:0] pos, input logic [7:0] c);
      logic hit;
      case (pos)
         3'd0: hit = (c == CharPlus);
         3'd1: hit = (c == CharI);
         3'd2: hit = (c == CharP);
         3'd3: hit = (c == CharD);
         3'd4: hit = (c == CharComma);
         default: hit = 1'b0;
      endcase
      if (hit) return pos + 3'd1;
      if (pos == 3'd1 && c == CharPlus) return 3'd1;
      return 3'd0;
   endfunction

   function automatic void open_length();
      length_on = 1'b1;
      len_count = 3'd0;
      len_left  = 16'd0;
   endfunction

   // advance the frame state by one byte and return the result it gives
   function automatic deframe_result_type deframe_byte(input logic [7:0] c);
      deframe_result_type r;
      r = '0;
      // frame body
      if (payload_on) begin
         if (len_left != 16'd0) begin
            len_left = len_left - 16'd1;
            r.payload_valid = 1'b1;
            r.payload_byte  = c;
         end else begin
            payload_on = 1'b0;
            len_left   = 16'd0;
            length_on  = 1'b0;
         end
      end
      // length field
      if (length_on) begin
         if (len_count <= MaxLenCount) begin
            len_count = len_count + 3'd1;
            if (c == CharColon) begin
               length_on  = 1'b0;
               len_count  = 3'd0;
               payload_on = 1'b1;
            end else if (is_len_digit(c)) begin
               len_left = len_left * 16'd10 + {12'd0, c[3:0]};
            end
         end else begin
            len_count = 3'd0;
         end
      end
      // "+IPD," matcher
      if (short_pos == 3'd4 && c == CharComma) begin
         short_pos = 3'd0;
         open_length();
      end else begin
         short_pos = prefix_next(short_pos, c);
         if (short_pos > 3'd4) short_pos = 3'd0;
      end
      // "+IPD,<digit>," matcher
      if (long_pos == 3'd5 && is_len_digit(c)) begin
         long_pos        = 3'd6;
         r.link_id_valid = 1'b1;
         r.link_id_char  = c[5:0];
      end else if (long_pos == 3'd6 && c == CharComma) begin
         long_pos = 3'd0;
         open_length();
      end else begin
         long_pos = prefix_next(long_pos, c);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= PrintLimit)
         $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
   endtask

   // result check, input capture and watchdog
   always @(posedge clock) begin
      deframe_result_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", 0, 1);
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload_valid !== want.payload_valid)
                  report_mismatch("payload_valid", want.payload_valid, rsp_payload_valid);
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", want.payload_byte, rsp_payload_byte);
               if (rsp_link_id_valid !== want.link_id_valid)
                  report_mismatch("link_id_valid", want.link_id_valid, rsp_link_id_valid);
               if (rsp_link_id_char !== want.link_id_char)
                  report_mismatch("link_id_char", want.link_id_char, rsp_link_id_char);
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(deframe_byte(req_rx_byte));
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= StallLimit) begin
            $display("tb_top failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_cnt  = HoldCycles;
      end
      if (hold_cnt > 0) begin
         hold_cnt  = hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // one transfer on the request channel, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_byte(s[k]);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // mostly frame characters, sometimes any byte
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return CharPlus;
         1: return CharI;
         2: return CharP;
         3: return CharD;
         4: return CharComma;
         5: return CharColon;
         6: return CharZero + 8'($urandom_range(0, 9));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one frame with random content, now and then broken or cut short
   task automatic send_random_frame();
      int unsigned kind, len, cut, inject_at, k;
      string hdr, digits;
      for (k = $urandom_range(0, 3); k > 0; k--) send_byte(noise_byte());
      kind = $urandom_range(0, 9);
      hdr  = (kind % 2) ? "+IPD," : $sformatf("+IPD,%0d,", $urandom_range(0, 9));
      if (kind == 0) begin
         cut = $urandom_range(1, hdr.len() - 1);
         for (k = 0; k < cut; k++) send_byte(hdr[k]);
         send_byte(noise_byte());
         return;
      end
      send_text(hdr);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
      digits = (len == 0 && $urandom_range(0, 2) == 0) ? "" : $sformatf("%0d", len);
      if ($urandom_range(0, 9) == 0) digits = {"0", digits};
      if ($urandom_range(0, 9) == 0) digits = {digits, "x"};
      send_text(digits);
      send_byte(CharColon);
      inject_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len + 1;
      for (k = 0; k < len; k++) begin
         if (k == inject_at) send_text("+IPD,");
         send_byte(8'($urandom_range(0, 255)));
      end
      // closing byte
      send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic run_random(input int unsigned idle, input int unsigned stall,
                             input int unsigned count);
      int unsigned start;
      idle_pct  = idle;
      stall_pct = stall;
      start     = bytes_sent;
      while (bytes_sent - start < count) send_random_frame();
      wait_drained();
   endtask

   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      // plus repeated at position one, link digit, empty frame
      send_text("++IPD,9,0:q");
      // length wraps modulo 65536, byte extremes in the body
      send_text("+IPD,0,65539:");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("a.");
      // more than six length characters: one is skipped
      send_text("+IPD,1aaaaa7:kz");
      // a header inside the body restarts the frame
      send_text("+IPD,4:ab+IPD,1:cw");
      wait_drained();
   endtask

   task automatic test_no_idle();
      run_random(0, 0, 230);
   endtask

   task automatic test_sender_idle();
      run_random(83, 0, 230);
   endtask

   task automatic test_receiver_stall();
      run_random(0, 83, 230);
   endtask

   task automatic test_both_idle();
      run_random(8, 8, 230);
   endtask

   // receiver holds off while the sender keeps offering bytes
   task automatic test_receiver_hold();
      idle_pct  = 0;
      stall_pct = 0;
      hold_seq++;
      while (bytes_sent % 120 != 0 || hold_cnt == 0) begin
         send_byte(noise_byte());
         if (hold_cnt == 0 && bytes_sent % 120 == 0) break;
      end
      run_random(0, 0, 60);
   endtask

   // sender pauses until every result is back, then goes on
   task automatic test_drain_pause();
      run_random(8, 50, 40);
      wait_drained();
      run_random(50, 8, 40);
   endtask

   initial begin
      short_pos  = 3'd0;
      long_pos   = 3'd0;
      len_left   = 16'd0;
      length_on  = 1'b0;
      payload_on = 1'b0;
      len_count  = 3'd0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_receiver_hold();
      test_drain_pause();

      wait_drained();
      repeat (TailCycles) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("results missing", 0, expected_q.size());
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
